// ===== rtl/srt_pkg.sv =====
// Shared types and constants for the sorted record table.
// Record layout, request and status codes, cell control and compare flags.
// No dependencies.
package srt_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int ENTRY_W     = 7;

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_DELETE = 2'd1;
	localparam logic [1:0] REQ_LOOKUP = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [15:0] key;
		logic [7:0]  year;
		logic [15:0] a_id;
		logic [7:0]  a_grade;
		logic [15:0] b_id;
		logic [7:0]  b_grade;
		logic [15:0] c_id;
		logic [7:0]  c_grade;
	} record_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_DELETE
	} cell_op_t;

	typedef struct packed {
		cell_op_t    op;
		logic [15:0] key;
	} cell_ctrl_t;

	typedef struct packed {
		logic lt;
		logic le;
		logic eq;
	} cell_flags_t;

endpackage

// ===== rtl/sorted_record_table.sv =====
// Sorted record table, top level. Depends on srt_pkg and srt_cell.
//
// Usage:
//   Requests arrive on the in_* channel (valid/ready): insert, delete by key
//   or lookup by key. Each request gives exactly one result on the out_*
//   channel (valid/ready): status, the found record on a lookup hit (zero
//   otherwise) and the record count after the request.
//   Records sit in a row of entry cells in ascending key order. After a
//   request is taken, every cell compares its key and registers the flags;
//   once the output register is free, the cells shift one place away from
//   the insert point or over the deleted entry, and the result is written
//   to the output register. The next request is taken in the cycle that the
//   previous one completes.
//   Reset clears the record count and both channels; record contents are
//   not cleared and are never read before being written.
//   A stalled receiver holds the result; the next request is compared and
//   then waits, with the input held off, until the output register frees.
module sorted_record_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  req_type,
	input  logic [15:0]                 key,
	input  logic [7:0]                  year_in,
	input  logic [15:0]                 course_a_id,
	input  logic [7:0]                  course_a_grade,
	input  logic [15:0]                 course_b_id,
	input  logic [7:0]                  course_b_grade,
	input  logic [15:0]                 course_c_id,
	input  logic [7:0]                  course_c_grade,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  status,
	output logic [15:0]                 key_out,
	output logic [7:0]                  year_out,
	output logic [15:0]                 out_a_id,
	output logic [7:0]                  out_a_grade,
	output logic [15:0]                 out_b_id,
	output logic [7:0]                  out_b_grade,
	output logic [15:0]                 out_c_id,
	output logic [7:0]                  out_c_grade,
	output logic [srt_pkg::ENTRY_W-1:0] entry_count
);
	import srt_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_ACT
	} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     fill_q;
	logic [CNT_W-1:0]     fill_next;
	logic                 out_valid_q;
	logic [1:0]           req_q;
	record_t              new_q;
	logic [1:0]           status_q;
	record_t              res_q;
	logic [ENTRY_W-1:0]   count_q;

	record_t              rec   [TABLE_DEPTH];
	cell_flags_t          flags [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] occ;
	logic [TABLE_DEPTH-1:0] hit;
	logic                 found;
	logic                 full;
	logic                 fire;
	logic                 take;
	record_t              hit_rec;
	record_t              in_rec;
	cell_ctrl_t           ctrl;
	logic [1:0]           status_next;

	localparam cell_flags_t HEAD_FLAGS = '{lt: 1'b1, le: 1'b1, eq: 1'b0};

	assign in_rec = '{key: key, year: year_in,
		a_id: course_a_id, a_grade: course_a_grade,
		b_id: course_b_id, b_grade: course_b_grade,
		c_id: course_c_id, c_grade: course_c_grade};

	assign full     = (fill_q == CNT_W'(TABLE_DEPTH));
	assign fire     = (state_q == S_ACT) && (!out_valid_q || out_ready);
	assign in_ready = (state_q == S_IDLE) || fire;
	assign take     = in_valid && in_ready;

	always_comb begin
		ctrl.key = new_q.key;
		ctrl.op  = OP_HOLD;
		if (fire && (req_q == REQ_INSERT) && !full) begin
			ctrl.op = OP_INSERT;
		end else if (fire && (req_q == REQ_DELETE) && found) begin
			ctrl.op = OP_DELETE;
		end
	end

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		assign occ[g] = (CNT_W'(g) < fill_q);
		if (g == 0) begin : g_head
			assign hit[g] = flags[g].eq;
			srt_cell u_cell (
				.clk        (clk),
				.ctrl       (ctrl),
				.occ        (occ[g]),
				.new_rec    (new_q),
				.left_rec   (new_q),
				.left_flags (HEAD_FLAGS),
				.right_rec  (rec[g+1]),
				.rec        (rec[g]),
				.flags      (flags[g])
			);
		end else if (g == TABLE_DEPTH - 1) begin : g_tail
			assign hit[g] = flags[g].eq && flags[g-1].lt;
			srt_cell u_cell (
				.clk        (clk),
				.ctrl       (ctrl),
				.occ        (occ[g]),
				.new_rec    (new_q),
				.left_rec   (rec[g-1]),
				.left_flags (flags[g-1]),
				.right_rec  (rec[g]),
				.rec        (rec[g]),
				.flags      (flags[g])
			);
		end else begin : g_mid
			assign hit[g] = flags[g].eq && flags[g-1].lt;
			srt_cell u_cell (
				.clk        (clk),
				.ctrl       (ctrl),
				.occ        (occ[g]),
				.new_rec    (new_q),
				.left_rec   (rec[g-1]),
				.left_flags (flags[g-1]),
				.right_rec  (rec[g+1]),
				.rec        (rec[g]),
				.flags      (flags[g])
			);
		end
	end

	assign found = |hit;

	always_comb begin
		hit_rec = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			hit_rec = hit_rec | (hit[i] ? rec[i] : record_t'('0));
		end
	end

	always_comb begin
		fill_next   = fill_q;
		status_next = ST_MISS;
		unique case (ctrl.op)
			OP_INSERT: fill_next = fill_q + CNT_W'(1);
			OP_DELETE: fill_next = fill_q - CNT_W'(1);
			default:   fill_next = fill_q;
		endcase
		priority if (req_q == REQ_INSERT) begin
			status_next = full ? ST_FULL : ST_OK;
		end else if ((req_q == REQ_DELETE) || (req_q == REQ_LOOKUP)) begin
			status_next = found ? ST_OK : ST_MISS;
		end else begin
			status_next = ST_MISS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_ACT;
				end
				S_ACT: begin
					if (fire) begin
						state_q <= take ? S_CMP : S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (fire) begin
				fill_q      <= fill_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			req_q <= req_type;
			new_q <= in_rec;
		end
		if (fire) begin
			status_q <= status_next;
			res_q    <= ((req_q == REQ_LOOKUP) && found) ? hit_rec : record_t'('0);
			count_q  <= ENTRY_W'(fill_next);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign key_out     = res_q.key;
	assign year_out    = res_q.year;
	assign out_a_id    = res_q.a_id;
	assign out_a_grade = res_q.a_grade;
	assign out_b_id    = res_q.b_id;
	assign out_b_grade = res_q.b_grade;
	assign out_c_id    = res_q.c_id;
	assign out_c_grade = res_q.c_grade;
	assign entry_count = count_q;

endmodule

// ===== rtl/srt_cell.sv =====
// One entry of the sorted record table: holds a record and its compare flags.
// Shifts towards either neighbour on insert or delete.
// Depends on srt_pkg.
module srt_cell (
	input  logic                clk,
	input  srt_pkg::cell_ctrl_t ctrl,
	input  logic                occ,
	input  srt_pkg::record_t    new_rec,
	input  srt_pkg::record_t    left_rec,
	input  srt_pkg::cell_flags_t left_flags,
	input  srt_pkg::record_t    right_rec,
	output srt_pkg::record_t    rec,
	output srt_pkg::cell_flags_t flags
);
	import srt_pkg::*;

	record_t     rec_q;
	cell_flags_t flags_q;
	cell_flags_t cmp;

	always_comb begin
		cmp.lt = occ && (rec_q.key <  ctrl.key);
		cmp.le = occ && (rec_q.key <= ctrl.key);
		cmp.eq = occ && (rec_q.key == ctrl.key);
	end

	always_ff @(posedge clk) begin
		flags_q <= cmp;
		unique case (ctrl.op)
			OP_INSERT: begin
				if (!flags_q.le) begin
					if (left_flags.le) begin
						rec_q <= new_rec;
					end else begin
						rec_q <= left_rec;
					end
				end
			end
			OP_DELETE: begin
				if (!flags_q.lt) begin
					rec_q <= right_rec;
				end
			end
			default: begin
			end
		endcase
	end

	assign rec   = rec_q;
	assign flags = flags_q;

endmodule

// ===== rtl/srt_checker.sv =====
// Port-level checks for the sorted record table, bound to the top level.
// Depends on srt_pkg and sorted_record_table.
module srt_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [1:0]                  status,
	input logic [15:0]                 key_out,
	input logic [7:0]                  year_out,
	input logic [srt_pkg::ENTRY_W-1:0] entry_count
);
	import srt_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken during compare cycle");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_FULL) |-> entry_count == ENTRY_W'(TABLE_DEPTH))
		else $error("full reported below capacity");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> (key_out == '0) && (year_out == '0))
		else $error("record fields set on a miss");

endmodule

bind sorted_record_table srt_checker u_srt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.status      (status),
	.key_out     (key_out),
	.year_out    (year_out),
	.entry_count (entry_count)
);
